>>> hdl/vmss_pkg.sv
// Shared types, widths and codes for the VM stack segment.
`default_nettype none

package vmss_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int ENV_SIZE_DEF    = 4;
  localparam int CELL_BITS_DEF   = 64;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 64;
  localparam int OFFSET_W = 10;
  localparam int FRAME_W  = 11;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_RDIDX  = 3'd3,
    KIND_WRIDX  = 3'd4,
    KIND_GLOBAL = 3'd5,
    KIND_LOCAL  = 3'd6,
    KIND_FORMAL = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_now;
    logic load_mem;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
    logic out_free;
  } dp_sts_t;

endpackage : vmss_pkg

`default_nettype wire

>>> hdl/vmss_mem.sv
// Cell store: one write port and one read port with registered read data.
`default_nettype none

module vmss_mem
  import vmss_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int CELL_BITS   = CELL_BITS_DEF,
  localparam int ADDR_W     = $clog2(STACK_DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_W-1:0]    wr_addr,
  input  wire logic [CELL_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output logic      [CELL_BITS-1:0] rd_data
);

  logic [CELL_BITS-1:0] cells [STACK_DEPTH];
  logic [CELL_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cells[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : vmss_mem

`default_nettype wire

>>> hdl/vmss_ctrl.sv
// Controller state machine: capture, execute and memory read steps.
`default_nettype none

module vmss_ctrl
  import vmss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_sts_t   sts,
  output ctrl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.need_read)     state_nxt = S_READ;
        else if (sts.out_free) state_nxt = S_IDLE;
      end
      S_READ: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        // A read item executes at once; its result is loaded after the memory read.
        if (sts.need_read) begin
          cmd.exec = 1'b1;
        end else if (sts.out_free) begin
          cmd.exec     = 1'b1;
          cmd.load_now = 1'b1;
        end
      end
      S_READ: begin
        cmd.load_mem = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule : vmss_ctrl

`default_nettype wire

>>> hdl/vmss_dp.sv
// Datapath: item registers, top pointer, address checks, store and result register.
`default_nettype none

module vmss_dp
  import vmss_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ENV_SIZE    = ENV_SIZE_DEF,
  parameter int CELL_BITS   = CELL_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctrl_cmd_t           cmd,
  output dp_sts_t                  sts,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [VALUE_W-1:0]  in_cell_value,
  input  wire logic [OFFSET_W-1:0] in_offset,
  input  wire logic [FRAME_W-1:0]  in_frame_top,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [VALUE_W-1:0]       out_read_value,
  output logic [STATUS_W-1:0]      out_status,
  output logic [DEPTH_W-1:0]       out_depth_used
);

  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int EW     = ((PTR_W > FRAME_W) ? PTR_W : FRAME_W) + 2;

  localparam logic [PTR_W-1:0]     DEPTH_P = PTR_W'(STACK_DEPTH);
  localparam logic [PTR_W-1:0]     ONE_P   = PTR_W'(1);
  localparam logic signed [EW-1:0] DEPTH_E = EW'(STACK_DEPTH);
  localparam logic signed [EW-1:0] ONE_E   = EW'(1);
  localparam logic signed [EW-1:0] ENV_E   = EW'(ENV_SIZE + 1);

  // Item registers.
  kind_t                kind_r;
  logic [CELL_BITS-1:0] value_r;
  logic [OFFSET_W-1:0]  offset_r;
  logic [FRAME_W-1:0]   frame_r;

  // Control state. Cells below min_top_r were never written since reset.
  logic [PTR_W-1:0] top_r, top_nxt;
  logic [PTR_W-1:0] min_top_r, min_top_nxt;
  logic             rd_zero_r;
  logic             out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r;
  status_t             out_status_r;
  logic [DEPTH_W-1:0]  out_depth_r;

  // Execute-step decode.
  logic [PTR_W-1:0]     used;
  logic [PTR_W-1:0]     top_m1;
  logic signed [EW-1:0] off_e, frame_e, top_e, used_e, la, idx_e;
  logic                 la_ok, idx_ok, la_below;
  logic [PTR_W-1:0]     new_top;
  logic                 wr_en, rd_en, rd_zero;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [CELL_BITS-1:0] wr_data;
  status_t              res_status;
  logic [CELL_BITS-1:0] mem_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= kind_t'(in_kind);
      value_r  <= CELL_BITS'(in_cell_value);
      offset_r <= in_offset;
      frame_r  <= in_frame_top;
    end
  end

  always_comb begin
    used    = DEPTH_P - top_r;
    top_m1  = top_r - ONE_P;
    off_e   = EW'(offset_r);
    frame_e = EW'(frame_r);
    top_e   = EW'(top_r);
    used_e  = EW'(used);
    idx_e   = DEPTH_E - ONE_E - off_e;
    idx_ok  = off_e < used_e;

    case (kind_r)
      KIND_GLOBAL: la = DEPTH_E - ONE_E - off_e;
      KIND_LOCAL:  la = frame_e - off_e;
      default:     la = frame_e + ENV_E + off_e;
    endcase
    la_ok    = !la[EW-1] && (la < DEPTH_E);
    la_below = la < top_e;

    new_top    = top_r;
    wr_en      = 1'b0;
    wr_addr    = top_m1[ADDR_W-1:0];
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = top_r[ADDR_W-1:0];
    rd_zero    = 1'b0;
    res_status = STAT_OK;

    case (kind_r)
      KIND_PUSH: begin
        if (top_r == '0) begin
          res_status = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_data = value_r;
          new_top = top_m1;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (used == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          rd_en = 1'b1;
          if (kind_r == KIND_POP) new_top = top_r + ONE_P;
        end
      end
      KIND_RDIDX: begin
        if (!idx_ok) begin
          res_status = STAT_RANGE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_e[ADDR_W-1:0];
        end
      end
      KIND_WRIDX: begin
        if (!idx_ok) begin
          res_status = STAT_RANGE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_e[ADDR_W-1:0];
          wr_data = value_r;
        end
      end
      default: begin
        if (!la_ok) begin
          res_status = STAT_RANGE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = la[ADDR_W-1:0];
          // A never-written cell reads as zero; so does the cell just pushed.
          rd_zero = (la < EW'(min_top_r)) || (la_below && (la == top_e - ONE_E));
          if (la_below) begin
            wr_en   = 1'b1;
            new_top = top_m1;
          end
        end
      end
    endcase
  end

  always_comb begin
    top_nxt     = cmd.exec ? new_top : top_r;
    min_top_nxt = (top_nxt < min_top_r) ? top_nxt : min_top_r;
    if (cmd.load_now || cmd.load_mem) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= DEPTH_P;
      min_top_r   <= DEPTH_P;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      min_top_r   <= min_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_zero_r <= rd_zero;
    end
    if (cmd.load_now) begin
      out_value_r  <= '0;
      out_status_r <= res_status;
      out_depth_r  <= DEPTH_W'(DEPTH_P - top_nxt);
    end else if (cmd.load_mem) begin
      out_value_r  <= rd_zero_r ? '0 : VALUE_W'(mem_q);
      out_status_r <= STAT_OK;
      out_depth_r  <= DEPTH_W'(DEPTH_P - top_r);
    end
  end

  vmss_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .CELL_BITS   (CELL_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (cmd.exec && wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.exec && rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  assign sts.need_read  = rd_en;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_depth_used = out_depth_r;

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= DEPTH_P)
    else $error("top pointer beyond stack depth");

  a_fill_mark: assert property (@(posedge clk) disable iff (!rst_n)
    min_top_r <= top_r)
    else $error("fill mark above top pointer");

  a_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && wr_en && rd_en && (wr_addr == rd_addr)) |-> rd_zero)
    else $error("read of the cell being written is not forced to zero");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_value_r == '0))
    else $error("failed item carries a nonzero value");

endmodule : vmss_dp

`default_nettype wire

>>> hdl/vm_stack_segment.sv
// A result is loaded from the execute step, or from the memory read step for reads and
// lookups; that step waits while the output register holds a result not yet taken.
// The controller takes one item at a time through capture, execute and registered memory read.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) empties the stack and sets the fill mark to the depth,
// so every never-written cell reads as zero without a clearing pass.
`default_nettype none

module vm_stack_segment
  import vmss_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ENV_SIZE    = ENV_SIZE_DEF,
  parameter int CELL_BITS   = CELL_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [VALUE_W-1:0]  in_cell_value,
  input  wire logic [OFFSET_W-1:0] in_offset,
  input  wire logic [FRAME_W-1:0]  in_frame_top,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [VALUE_W-1:0]       out_read_value,
  output logic [STATUS_W-1:0]      out_status,
  output logic [DEPTH_W-1:0]       out_depth_used
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  vmss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vmss_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .ENV_SIZE    (ENV_SIZE),
    .CELL_BITS   (CELL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_cell_value  (in_cell_value),
    .in_offset      (in_offset),
    .in_frame_top   (in_frame_top),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_depth_used (out_depth_used)
  );

endmodule : vm_stack_segment

`default_nettype wire
